/* src/clock_skew_anomaly_detector_unit_defines.svh */
// ----------------------------------------------------------------------------
// Clock skew anomaly detector assertion macros
// Shared property forms for the checker, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef CLOCK_SKEW_ANOMALY_DETECTOR_UNIT_DEFINES_SVH
`define CLOCK_SKEW_ANOMALY_DETECTOR_UNIT_DEFINES_SVH

// Same-cycle implication
`define CSAD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define CSAD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/csad_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csad_pkg
// Fixed-point constants, types and saturating helpers for the skew detector.
// ----------------------------------------------------------------------------
package csad_pkg;

  localparam int F      = 32;            // fraction bits of every Q value
  localparam int QW     = 64;            // Q word width
  localparam int TS_W   = 63;            // timestamp width
  localparam int DW     = QW + F;        // divider dividend width
  localparam int RW     = DW + (DW % 2); // square root radicand width
  localparam int RH     = RW / 2;        // square root result width
  localparam int CFG_IDX_W = 3;

  typedef logic signed [QW-1:0] q_t;
  typedef logic [TS_W-1:0]      ts_t;

  localparam logic [QW-1:0] Q_ONE = QW'(1) << F;
  localparam logic [QW-1:0] QMAX  = {1'b0, {(QW-1){1'b1}}};
  localparam logic [QW-1:0] QMIN  = {1'b1, {(QW-1){1'b0}}};

  localparam logic [62:0] NP_RST   = 63'(Q_ONE);
  localparam logic [33:0] FINV_RST = 34'((Q_ONE * 100) / 99);
  localparam logic [62:0] ICOV_RST = 63'(Q_ONE * 100);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NOMINAL_PERIOD = 3'd0,
    REG_BASE_MEAN      = 3'd1,
    REG_BASE_DEV       = 3'd2,
    REG_ALARM_SIGMA    = 3'd3,
    REG_FORGET_INV     = 3'd4,
    REG_INIT_COV       = 3'd5,
    REG_MIN_RUN        = 3'd6
  } cfg_reg_e;

  function automatic logic [QW-1:0] mag_f(q_t a);
    return a[QW-1] ? QW'(-a) : QW'(a);
  endfunction

  function automatic q_t from_mag_f(logic neg, logic [QW-1:0] m);
    if (neg) begin
      return (m > QMAX) ? q_t'(QMIN) : -q_t'(m);
    end
    return (m > QMAX) ? q_t'(QMAX) : q_t'(m);
  endfunction

  function automatic q_t sat_add_f(q_t a, q_t b);
    q_t s;
    s = a + b;
    if (a[QW-1] == b[QW-1] && s[QW-1] != a[QW-1]) begin
      return a[QW-1] ? q_t'(QMIN) : q_t'(QMAX);
    end
    return s;
  endfunction

  function automatic q_t sat_sub_f(q_t a, q_t b);
    q_t d;
    d = a - b;
    if (a[QW-1] != b[QW-1] && d[QW-1] != a[QW-1]) begin
      return a[QW-1] ? q_t'(QMIN) : q_t'(QMAX);
    end
    return d;
  endfunction

  // Truncate a full product to Q and saturate
  function automatic q_t qfin_f(logic neg, logic [2*QW-1:0] p);
    logic [QW-1:0] r;
    r = (|p[2*QW-1:QW+F]) ? '1 : p[QW+F-1:F];
    return from_mag_f(neg, r);
  endfunction

  // Saturate a wide quotient to Q
  function automatic q_t qsat_f(logic neg, logic [DW-1:0] q);
    logic [QW-1:0] r;
    r = (|q[DW-1:QW]) ? '1 : q[QW-1:0];
    return from_mag_f(neg, r);
  endfunction

endpackage

/* src/csad_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csad_in_if / csad_out_if
// Valid/ready channels carrying frame requests and detector results.
// ----------------------------------------------------------------------------
interface csad_in_if import csad_pkg::*; ();
  logic valid;
  logic ready;
  logic command;
  ts_t  arrival_time;

  modport source (output valid, command, arrival_time, input ready);
  modport sink   (input valid, command, arrival_time, output ready);
endinterface

interface csad_out_if import csad_pkg::*; ();
  logic        valid;
  logic        ready;
  q_t          skew_estimate;
  logic        anomalous;
  logic        run_report;
  ts_t         run_start;
  ts_t         run_end;
  logic [31:0] run_frames;
  q_t          run_mean_skew;
  ts_t         run_skew_deviation;

  modport source (output valid, skew_estimate, anomalous, run_report, run_start, run_end,
                  run_frames, run_mean_skew, run_skew_deviation, input ready);
  modport sink   (input valid, skew_estimate, anomalous, run_report, run_start, run_end,
                  run_frames, run_mean_skew, run_skew_deviation, output ready);
endinterface

/* src/csad_mul.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csad_mul
// Bit-serial unsigned 64x64 multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module csad_mul import csad_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [QW-1:0]     a_i,
  input  logic [QW-1:0]     b_i,
  output logic              done_o,
  output logic [2*QW-1:0]   prod_o
);

  localparam int CW = $clog2(QW + 1);

  logic          busy_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [QW-1:0] hi_q, lo_q, mc_q;
  logic [QW:0]   sum;

  // add the multiplicand when the low bit is set
  assign sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, mc_q} : '0);

  // control: count the bits, pulse done at the end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(QW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath: shift the partial product right one bit per cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      hi_q <= '0;
      lo_q <= b_i;
      mc_q <= a_i;
    end else if (busy_q) begin
      hi_q <= sum[QW:1];
      lo_q <= {sum[0], lo_q[QW-1:1]};
    end
  end

  assign done_o = done_q;
  assign prod_o = {hi_q, lo_q};

endmodule

/* src/csad_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csad_div
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module csad_div import csad_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [QW-1:0] divisor_i,
  output logic          done_o,
  output logic [DW-1:0] quot_o
);

  localparam int CW = $clog2(DW + 1);

  logic          busy_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [QW-1:0] rem_q, dvs_q;
  logic [DW-1:0] quo_q;
  logic [QW:0]   trial, diff;
  logic          ge;

  // shift in the next dividend bit and try a subtract
  assign trial = {rem_q, quo_q[DW-1]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(DW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // dividend leaves at the top while quotient bits enter at the bottom
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[QW-1:0] : trial[QW-1:0];
      quo_q <= {quo_q[DW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

/* src/csad_sqrt.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csad_sqrt
// Digit-by-digit floor square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module csad_sqrt import csad_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [RW-1:0] rad_i,
  output logic          done_o,
  output logic [RH-1:0] root_o
);

  localparam int CW = $clog2(RH + 1);

  logic          busy_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [RW-1:0] rad_q;
  logic [RH:0]   rem_q;
  logic [RH-1:0] root_q;
  logic [RH+2:0] r4, trial, diff;
  logic          ge;

  // bring down two radicand bits and test root*4+1
  assign r4    = {rem_q, rad_q[RW-1:RW-2]};
  assign trial = {1'b0, root_q, 2'b01};
  assign ge    = r4 >= trial;
  assign diff  = r4 - trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(RH);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= rad_q << 2;
      rem_q  <= ge ? diff[RH:0] : r4[RH:0];
      root_q <= {root_q[RH-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

/* src/clock_skew_anomaly_detector_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clock_skew_anomaly_detector_unit
// Clock skew estimator (forgetting-factor RLS) with anomalous run reporting.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one request per frame: command 0 is a frame arrival with its
//   Q31.32 timestamp, command 1 flushes any open anomalous run. out_o returns
//   exactly one result per request: current skew, anomaly flag and, when a
//   long enough run closes, its start, end, frame count, mean and deviation.
//   Configuration registers are written through cfg_we_i/cfg_idx_i/cfg_data_i;
//   the user must do so while the block is idle; it is not enforced.
// Sequencing:
//   Every multiply runs bit-serially on one shared unit and holds its step
//   until done; divide and square root steps likewise wait for their units.
//   A frame result is registered after nine multiplies and one divide, with
//   one more multiply when the frame is anomalous, and two divides, one
//   multiply and one root more when a run report is built; a flush without
//   a report goes from the run check straight to the output register. One
//   request is in work at a time; the next is taken only after the previous
//   result sits in the output register.
// Reset:
//   Registers return to their defaults, estimator and run state clear.
// Backpressure:
//   A stalled receiver holds the result; the next request may be computed
//   but its result waits until the output register frees up.
// ----------------------------------------------------------------------------
module clock_skew_anomaly_detector_unit import csad_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [QW-1:0]        cfg_data_i,
  csad_in_if.sink              in_i,
  csad_out_if.source           out_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_PROD, S_ACC, S_E, S_LP, S_NUM, S_DEN, S_G, S_GT, S_GTP, S_P,
    S_SK, S_THR, S_SQ, S_CLOSE, S_MEAN, S_VAR, S_MM, S_SQRT, S_OUT
  } state_e;

  // configuration registers
  logic [62:0] np_q, bdev_q, icov_q;
  q_t          bmean_q;
  logic [3:0]  sigma_q;
  logic [33:0] finv_q;
  logic [7:0]  minrun_q;

  // estimator and run state
  state_e      state_q;
  logic        go_q, started_q;
  ts_t         origin_q, last_q, ts_q, end_q, rs_start_q, run_start_q;
  logic [31:0] cnt_q, runlen_q, rs_frames_q;
  q_t          acc_q, skew_q, cov_q, sum_q, sqsum_q;
  q_t          el_q, e_q, tmp_q, num_q, g_q, mean_q, var_q, res_skew_q;
  logic [QW-1:0] den_q;
  ts_t         dev_q;
  logic        res_anom_q, rep_q;

  // output register
  logic        ov_q, o_anom_q, o_rep_q;
  q_t          o_skew_q, o_mean_q;
  ts_t         o_start_q, o_end_q, o_dev_q;
  logic [31:0] o_frames_q;

  // shared units
  logic              mul_start, mul_done, div_start, div_done, sq_start, sq_done;
  logic [QW-1:0]     mul_a, mul_b, div_dvs;
  logic [2*QW-1:0]   mul_prod;
  logic [DW-1:0]     div_dvd, div_quo;
  logic [RH-1:0]     sq_root;
  logic              mul_neg, is_mul;
  q_t                opx, opy, qm, den_c, acc_c;
  logic [QW-1:0]     prod_sat, el_u, raw_d, absd, gap;
  logic [QW:0]       psum;
  logic [67:0]       thr;
  logic              anom_c, accept, out_free;

  assign accept   = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == S_IDLE);
  assign out_free = !ov_q || out_o.ready;

  // select multiplier operands
  always_comb begin
    opx    = '0;
    opy    = '0;
    is_mul = 1'b1;
    case (state_q)
      S_E:   begin opx = skew_q;             opy = el_q;   end
      S_LP:  begin opx = q_t'({30'b0, finv_q}); opy = cov_q;  end
      S_NUM: begin opx = tmp_q;              opy = el_q;   end
      S_DEN: begin opx = num_q;              opy = el_q;   end
      S_GT:  begin opx = g_q;                opy = el_q;   end
      S_GTP: begin opx = tmp_q;              opy = cov_q;  end
      S_P:   begin opx = q_t'({30'b0, finv_q}); opy = tmp_q;  end
      S_SK:  begin opx = g_q;                opy = e_q;    end
      S_SQ:  begin opx = skew_q;             opy = skew_q; end
      S_MM:  begin opx = mean_q;             opy = mean_q; end
      S_PROD: ;
      default: is_mul = 1'b0;
    endcase
    mul_a   = mag_f(opx);
    mul_b   = mag_f(opy);
    mul_neg = opx[QW-1] ^ opy[QW-1];
    if (state_q == S_PROD) begin
      mul_a   = {32'b0, cnt_q - 32'd1};
      mul_b   = {1'b0, np_q};
      mul_neg = 1'b0;
    end
  end

  assign mul_start = is_mul && !go_q;

  // select divider operands
  always_comb begin
    div_dvd = '0;
    div_dvs = {32'b0, runlen_q};
    case (state_q)
      S_G: begin
        div_dvd = {mag_f(num_q), {F{1'b0}}};
        div_dvs = den_q;
      end
      S_MEAN: div_dvd = DW'(mag_f(sum_q));
      S_VAR:  div_dvd = DW'(sqsum_q);
      default: ;
    endcase
  end

  assign div_start = (state_q == S_G || state_q == S_MEAN || state_q == S_VAR) && !go_q;
  assign sq_start  = (state_q == S_SQRT) && !go_q;

  // result shaping
  assign qm       = qfin_f(mul_neg, mul_prod);
  assign prod_sat = (|mul_prod[2*QW-1:QW]) ? '1 : mul_prod[QW-1:0];
  assign den_c    = sat_add_f(q_t'(Q_ONE), qm);

  // absolute offset from the predicted arrival
  always_comb begin
    el_u = QW'(el_q);
    psum = {1'b0, QW'(tmp_q)} + {1'b0, mag_f(el_q)};
    if (!el_q[QW-1]) begin
      raw_d = (el_u >= QW'(tmp_q)) ? el_u - QW'(tmp_q) : QW'(tmp_q) - el_u;
    end else begin
      raw_d = psum[QW] ? '1 : psum[QW-1:0];
    end
    absd  = (raw_d > QMAX) ? QMAX : raw_d;
    acc_c = sat_add_f(acc_q, q_t'(absd));
  end

  // threshold test on the updated skew
  always_comb begin
    gap    = (skew_q >= bmean_q) ? QW'(skew_q - bmean_q) : QW'(bmean_q - skew_q);
    thr    = 68'(sigma_q) * 68'(bdev_q);
    anom_c = (thr[67:64] == 4'd0) && (gap > thr[63:0]);
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      np_q     <= NP_RST;
      bmean_q  <= '0;
      bdev_q   <= '0;
      sigma_q  <= 4'd3;
      finv_q   <= FINV_RST;
      icov_q   <= ICOV_RST;
      minrun_q <= 8'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_NOMINAL_PERIOD: np_q     <= cfg_data_i[62:0];
        REG_BASE_MEAN:      bmean_q  <= q_t'(cfg_data_i);
        REG_BASE_DEV:       bdev_q   <= cfg_data_i[62:0];
        REG_ALARM_SIGMA:    sigma_q  <= cfg_data_i[3:0];
        REG_FORGET_INV:     finv_q   <= cfg_data_i[33:0];
        REG_INIT_COV:       icov_q   <= cfg_data_i[62:0];
        REG_MIN_RUN:        minrun_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // sequencer: state, estimator state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      go_q        <= 1'b0;
      started_q   <= 1'b0;
      origin_q    <= '0;
      last_q      <= '0;
      cnt_q       <= 32'd1;
      acc_q       <= '0;
      skew_q      <= '0;
      cov_q       <= q_t'({1'b0, ICOV_RST});
      runlen_q    <= '0;
      run_start_q <= '0;
      sum_q       <= '0;
      sqsum_q     <= '0;
      ov_q        <= 1'b0;
    end else begin
      if (ov_q && out_o.ready) begin
        ov_q <= 1'b0;
      end
      if (is_mul || state_q == S_G || state_q == S_MEAN || state_q == S_VAR ||
          state_q == S_SQRT) begin
        if (!go_q) begin
          go_q <= 1'b1;
        end else if (mul_done || div_done || sq_done) begin
          go_q <= 1'b0;
        end
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            ts_q <= in_i.arrival_time;
            rep_q <= 1'b0;
            if (in_i.command) begin
              res_skew_q <= skew_q;
              res_anom_q <= 1'b0;
              end_q      <= last_q;
              state_q    <= S_CLOSE;
            end else begin
              started_q <= 1'b1;
              last_q    <= in_i.arrival_time;
              end_q     <= in_i.arrival_time;
              if (!started_q) begin
                origin_q <= in_i.arrival_time;
                cov_q    <= q_t'({1'b0, icov_q});
                cnt_q    <= 32'd2;
                el_q     <= '0;
              end else begin
                cnt_q <= (cnt_q != '1) ? cnt_q + 32'd1 : cnt_q;
                el_q  <= q_t'({1'b0, in_i.arrival_time}) - q_t'({1'b0, origin_q});
              end
              state_q <= S_PROD;
            end
          end
        end
        S_PROD: if (go_q && mul_done) begin
          tmp_q   <= q_t'(prod_sat);
          state_q <= S_ACC;
        end
        S_ACC: begin
          acc_q   <= acc_c;
          state_q <= S_E;
        end
        S_E: if (go_q && mul_done) begin
          e_q     <= sat_sub_f(acc_q, qm);
          state_q <= S_LP;
        end
        S_LP: if (go_q && mul_done) begin
          tmp_q   <= qm;
          state_q <= S_NUM;
        end
        S_NUM: if (go_q && mul_done) begin
          num_q   <= qm;
          state_q <= S_DEN;
        end
        S_DEN: if (go_q && mul_done) begin
          den_q   <= (den_c[QW-1] || den_c == '0) ? QW'(1) : QW'(den_c);
          state_q <= S_G;
        end
        S_G: if (go_q && div_done) begin
          g_q     <= qsat_f(num_q[QW-1], div_quo);
          state_q <= S_GT;
        end
        S_GT: if (go_q && mul_done) begin
          tmp_q   <= qm;
          state_q <= S_GTP;
        end
        S_GTP: if (go_q && mul_done) begin
          tmp_q   <= sat_sub_f(cov_q, qm);
          state_q <= S_P;
        end
        S_P: if (go_q && mul_done) begin
          cov_q   <= qm[QW-1] ? '0 : qm;
          state_q <= S_SK;
        end
        S_SK: if (go_q && mul_done) begin
          skew_q  <= sat_add_f(skew_q, qm);
          state_q <= S_THR;
        end
        S_THR: begin
          res_skew_q <= skew_q;
          res_anom_q <= anom_c;
          state_q    <= anom_c ? S_SQ : S_CLOSE;
        end
        // extend the open run
        S_SQ: if (go_q && mul_done) begin
          if (runlen_q == '0) begin
            run_start_q <= ts_q;
            sum_q       <= skew_q;
            sqsum_q     <= qm;
          end else begin
            sum_q   <= sat_add_f(sum_q, skew_q);
            sqsum_q <= sat_add_f(sqsum_q, qm);
          end
          runlen_q <= (runlen_q != '1) ? runlen_q + 32'd1 : runlen_q;
          state_q  <= S_OUT;
        end
        // drop a short run, or start the report
        S_CLOSE: begin
          rs_start_q  <= run_start_q;
          rs_frames_q <= runlen_q;
          if (runlen_q < ((minrun_q != '0) ? 32'(minrun_q) : 32'd1)) begin
            runlen_q    <= '0;
            run_start_q <= '0;
            sum_q       <= '0;
            sqsum_q     <= '0;
            state_q     <= S_OUT;
          end else begin
            state_q <= S_MEAN;
          end
        end
        S_MEAN: if (go_q && div_done) begin
          mean_q  <= qsat_f(sum_q[QW-1], div_quo);
          state_q <= S_VAR;
        end
        S_VAR: if (go_q && div_done) begin
          var_q   <= q_t'(div_quo[QW-1:0]);
          state_q <= S_MM;
        end
        S_MM: if (go_q && mul_done) begin
          var_q   <= sat_sub_f(var_q, qm);
          state_q <= S_SQRT;
        end
        S_SQRT: begin
          if (!go_q && var_q[QW-1]) begin
            var_q <= '0;
          end
          if (go_q && sq_done) begin
            dev_q       <= TS_W'(sq_root);
            rep_q       <= 1'b1;
            runlen_q    <= '0;
            run_start_q <= '0;
            sum_q       <= '0;
            sqsum_q     <= '0;
            state_q     <= S_OUT;
          end
        end
        S_OUT: if (out_free) begin
          ov_q       <= 1'b1;
          o_skew_q   <= res_skew_q;
          o_anom_q   <= res_anom_q;
          o_rep_q    <= rep_q;
          o_start_q  <= rep_q ? rs_start_q : '0;
          o_end_q    <= rep_q ? end_q : '0;
          o_frames_q <= rep_q ? rs_frames_q : '0;
          o_mean_q   <= rep_q ? mean_q : '0;
          o_dev_q    <= rep_q ? dev_q : '0;
          state_q    <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // radicand: variance scaled up by the fraction bits, clamped at zero
  logic [RW-1:0] sq_rad;
  assign sq_rad = var_q[QW-1] ? '0 : RW'({QW'(var_q), {F{1'b0}}});

  csad_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  csad_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quot_o     (div_quo)
  );

  csad_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .rad_i   (sq_rad),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  assign out_o.valid              = ov_q;
  assign out_o.skew_estimate      = o_skew_q;
  assign out_o.anomalous          = o_anom_q;
  assign out_o.run_report         = o_rep_q;
  assign out_o.run_start          = o_start_q;
  assign out_o.run_end            = o_end_q;
  assign out_o.run_frames         = o_frames_q;
  assign out_o.run_mean_skew      = o_mean_q;
  assign out_o.run_skew_deviation = o_dev_q;

endmodule

/* src/csad_chk.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csad_chk
// Port-level checks of the skew detector, bound to the top level.
// ----------------------------------------------------------------------------
`include "clock_skew_anomaly_detector_unit_defines.svh"

module csad_chk import csad_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_anom,
  input logic        out_rep,
  input ts_t         out_start,
  input ts_t         out_end,
  input logic [31:0] out_frames,
  input q_t          out_mean,
  input ts_t         out_dev
);

  // hold a stalled result
  `CSAD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

  // report fields stay zero without a report
  `CSAD_ASSERT_IMPL(a_quiet_fields, out_valid && !out_rep, out_frames == '0 && out_start == '0 && out_end == '0 && out_mean == '0 && out_dev == '0, "report fields set without a report")

  // a report closes a nonempty run on a normal frame or a flush
  `CSAD_ASSERT_IMPL(a_report_run, out_valid && out_rep, !out_anom && out_frames != '0, "bad run report")

  // a taken request keeps the block busy the next cycle
  `CSAD_ASSERT_NEXT(a_busy_after_req, in_valid && in_ready, !in_ready, "request taken while busy")

endmodule

bind clock_skew_anomaly_detector_unit csad_chk u_csad_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid   (in_i.valid),
  .in_ready   (in_i.ready),
  .out_valid  (out_o.valid),
  .out_ready  (out_o.ready),
  .out_anom   (out_o.anomalous),
  .out_rep    (out_o.run_report),
  .out_start  (out_o.run_start),
  .out_end    (out_o.run_end),
  .out_frames (out_o.run_frames),
  .out_mean   (out_o.run_mean_skew),
  .out_dev    (out_o.run_skew_deviation)
);

/* tb/csad_result_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csad_result_checker
// Watches the configuration port and both channels of the skew detector,
// predicts the result of every accepted request in fixed point and compares
// the returned results in order, field by field.
// ----------------------------------------------------------------------------
module csad_result_checker import csad_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [QW-1:0]        cfg_data_i,
  csad_in_if                   in_mon,
  csad_out_if                  out_mon,
  output int                   fail_count_o,
  output int                   pending_o,
  output int                   reports_seen_o
);

  typedef logic [63:0] u64_t;

  typedef struct {
    q_t          skew_estimate;
    logic        anomalous;
    logic        run_report;
    ts_t         run_start;
    ts_t         run_end;
    logic [31:0] run_frames;
    q_t          run_mean_skew;
    ts_t         run_skew_deviation;
  } detect_res_t;

  localparam u64_t MAX63 = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam u64_t MAX32 = 64'h0000_0000_FFFF_FFFF;

  // register copies
  u64_t period_r;
  q_t   base_mean_r;
  u64_t base_dev_r;
  u64_t sigma_r;
  q_t   forget_r;
  q_t   init_cov_r;
  u64_t min_run_r;

  // estimator and run state
  logic started;
  u64_t origin_time;
  u64_t frame_cnt;
  q_t   offset_acc;
  q_t   skew_est;
  q_t   cov_est;
  u64_t run_len;
  u64_t run_t0;
  q_t   run_sum;
  q_t   run_sq_sum;
  u64_t last_seen;

  detect_res_t expected_q[$];

  function automatic u64_t abs_of(q_t a);
    return a[63] ? u64_t'(-a) : u64_t'(a);
  endfunction

  function automatic q_t signed_of(logic neg, u64_t m);
    if (neg) begin
      return (m > MAX63) ? q_t'(64'h8000_0000_0000_0000) : -q_t'(m);
    end
    return (m > MAX63) ? q_t'(MAX63) : q_t'(m);
  endfunction

  function automatic q_t add_clip(q_t a, q_t b);
    q_t s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) begin
      return signed_of(a[63], 64'hFFFF_FFFF_FFFF_FFFF);
    end
    return s;
  endfunction

  function automatic q_t sub_clip(q_t a, q_t b);
    q_t d;
    d = a - b;
    if (a[63] != b[63] && d[63] != a[63]) begin
      return signed_of(a[63], 64'hFFFF_FFFF_FFFF_FFFF);
    end
    return d;
  endfunction

  // exact product, truncate the fraction, saturate
  function automatic q_t fx_mul(q_t a, q_t b);
    logic [127:0] p;
    u64_t r;
    p = {64'b0, abs_of(a)} * {64'b0, abs_of(b)};
    r = (|p[127:96]) ? '1 : p[95:32];
    return signed_of(a[63] != b[63], r);
  endfunction

  // divisor must be positive
  function automatic q_t fx_div(q_t num, q_t den);
    logic [95:0] dvd, quo;
    u64_t r;
    dvd = {abs_of(num), 32'b0};
    quo = dvd / {32'b0, u64_t'(den)};
    r = (|quo[95:64]) ? '1 : quo[63:0];
    return signed_of(num[63], r);
  endfunction

  // floored square root of a non-negative Q value
  function automatic u64_t fx_root(q_t v);
    logic [127:0] target, sq;
    u64_t r, c;
    target = {32'b0, u64_t'(v), 32'b0};
    r = 0;
    for (int b = 62; b >= 0; b--) begin
      c = r | (u64_t'(1) << b);
      sq = {64'b0, c} * {64'b0, c};
      if (sq <= target) r = c;
    end
    return r;
  endfunction

  function automatic void clear_run_state();
    run_len    = 0;
    run_t0     = 0;
    run_sum    = 0;
    run_sq_sum = 0;
  endfunction

  // close the open run and fill the report when it is long enough
  function automatic void close_run_into(u64_t close_ts, ref detect_res_t res);
    u64_t need;
    u64_t root_v;
    q_t   mean, var_q;
    need = (min_run_r != 0) ? min_run_r : 1;
    if (run_len < need) begin
      clear_run_state();
      return;
    end
    mean  = signed_of(run_sum[63], abs_of(run_sum) / run_len);
    var_q = q_t'(u64_t'(run_sq_sum) / run_len);
    var_q = sub_clip(var_q, fx_mul(mean, mean));
    if (var_q < 0) var_q = 0;
    root_v = fx_root(var_q);
    res.run_report         = 1'b1;
    res.run_start          = run_t0[62:0];
    res.run_end            = close_ts[62:0];
    res.run_frames         = run_len[31:0];
    res.run_mean_skew      = mean;
    res.run_skew_deviation = root_v[62:0];
    clear_run_state();
  endfunction

  function automatic detect_res_t predict_frame(u64_t ts);
    detect_res_t  res;
    logic [127:0] prod_w, thr_w;
    u64_t         n, prod, absd, ue, me, gap;
    q_t           el, e, lp, num, den, g, p, sq;
    logic         anom;
    res = '{default: '0};
    if (!started) begin
      started     = 1'b1;
      origin_time = ts;
      frame_cnt   = 1;
      cov_est     = init_cov_r;
    end
    last_seen = ts;
    if (frame_cnt < MAX32) frame_cnt++;

    // absolute offset from the predicted arrival
    n      = frame_cnt - 1;
    prod_w = {64'b0, n} * {64'b0, period_r};
    prod   = (|prod_w[127:64]) ? '1 : prod_w[63:0];
    el     = q_t'(ts) - q_t'(origin_time);
    if (el >= 0) begin
      ue   = u64_t'(el);
      absd = (ue >= prod) ? ue - prod : prod - ue;
    end else begin
      me   = abs_of(el);
      absd = (prod > ~me) ? '1 : prod + me;
    end
    if (absd > MAX63) absd = MAX63;
    offset_acc = add_clip(offset_acc, q_t'(absd));

    // recursive least squares with forgetting
    e   = sub_clip(offset_acc, fx_mul(skew_est, el));
    lp  = fx_mul(forget_r, cov_est);
    num = fx_mul(lp, el);
    den = add_clip(q_t'(Q_ONE), fx_mul(num, el));
    if (den < 1) den = 1;
    g   = fx_div(num, den);
    p   = fx_mul(forget_r, sub_clip(cov_est, fx_mul(fx_mul(g, el), cov_est)));
    cov_est  = (p < 0) ? q_t'(0) : p;
    skew_est = add_clip(skew_est, fx_mul(g, e));

    // threshold against the trained baseline
    gap   = (skew_est >= base_mean_r) ? u64_t'(skew_est) - u64_t'(base_mean_r)
                                      : u64_t'(base_mean_r) - u64_t'(skew_est);
    thr_w = {64'b0, sigma_r} * {64'b0, base_dev_r};
    anom  = (|thr_w[127:64]) ? 1'b0 : (gap > thr_w[63:0]);

    res.skew_estimate = skew_est;
    res.anomalous     = anom;
    if (anom) begin
      sq = fx_mul(skew_est, skew_est);
      if (run_len == 0) begin
        run_t0     = ts;
        run_sum    = skew_est;
        run_sq_sum = sq;
      end else begin
        run_sum    = add_clip(run_sum, skew_est);
        run_sq_sum = add_clip(run_sq_sum, sq);
      end
      if (run_len < MAX32) run_len++;
    end else begin
      close_run_into(ts, res);
    end
    return res;
  endfunction

  function automatic detect_res_t predict_flush();
    detect_res_t res;
    res = '{default: '0};
    res.skew_estimate = skew_est;
    close_run_into(last_seen, res);
    return res;
  endfunction

  task automatic check_field(string name, u64_t exp_v, u64_t act_v);
    if (exp_v !== act_v) begin
      if (fail_count_o < 10) begin
        $display("MISMATCH %s: expected %h, got %h at %0t", name, exp_v, act_v, $realtime);
      end
      fail_count_o++;
    end
  endtask

  // compare, apply register writes, then predict new requests
  always @(posedge clk_i or negedge rst_ni) begin
    detect_res_t exp_r;
    if (!rst_ni) begin
      period_r     = u64_t'(NP_RST);
      base_mean_r  = 0;
      base_dev_r   = 0;
      sigma_r      = 3;
      forget_r     = q_t'(FINV_RST);
      init_cov_r   = q_t'(ICOV_RST);
      min_run_r    = 1;
      started      = 1'b0;
      origin_time  = 0;
      frame_cnt    = 1;
      offset_acc   = 0;
      skew_est     = 0;
      cov_est      = q_t'(ICOV_RST);
      last_seen    = 0;
      clear_run_state();
      expected_q.delete();
      fail_count_o   = 0;
      pending_o      = 0;
      reports_seen_o = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_q.size() == 0) begin
          if (fail_count_o < 10) $display("UNEXPECTED result at %0t", $realtime);
          fail_count_o++;
        end else begin
          exp_r = expected_q[0];
          expected_q.delete(0);
          if (out_mon.run_report === 1'b1) reports_seen_o++;
          check_field("skew_estimate", u64_t'(exp_r.skew_estimate),
                      u64_t'(out_mon.skew_estimate));
          check_field("anomalous", u64_t'(exp_r.anomalous), u64_t'(out_mon.anomalous));
          check_field("run_report", u64_t'(exp_r.run_report), u64_t'(out_mon.run_report));
          check_field("run_start", u64_t'(exp_r.run_start), u64_t'(out_mon.run_start));
          check_field("run_end", u64_t'(exp_r.run_end), u64_t'(out_mon.run_end));
          check_field("run_frames", u64_t'(exp_r.run_frames), u64_t'(out_mon.run_frames));
          check_field("run_mean_skew", u64_t'(exp_r.run_mean_skew),
                      u64_t'(out_mon.run_mean_skew));
          check_field("run_skew_deviation", u64_t'(exp_r.run_skew_deviation),
                      u64_t'(out_mon.run_skew_deviation));
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_NOMINAL_PERIOD: period_r    = cfg_data_i & MAX63;
          REG_BASE_MEAN:      base_mean_r = q_t'(cfg_data_i);
          REG_BASE_DEV:       base_dev_r  = cfg_data_i & MAX63;
          REG_ALARM_SIGMA:    sigma_r     = cfg_data_i & 64'hF;
          REG_FORGET_INV:     forget_r    = q_t'({30'b0, cfg_data_i[33:0]});
          REG_INIT_COV:       init_cov_r  = q_t'(cfg_data_i & MAX63);
          REG_MIN_RUN:        min_run_r   = cfg_data_i & 64'hFF;
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.command) begin
          expected_q.insert(expected_q.size(), predict_flush());
        end else begin
          expected_q.insert(expected_q.size(), predict_frame({1'b0, in_mon.arrival_time}));
        end
      end
      pending_o = expected_q.size();
    end
  end

endmodule

/* tb/tb_clock_skew_anomaly_detector_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_clock_skew_anomaly_detector_unit
// Drives frame and flush requests into the skew detector through directed
// corner cases and randomized phases of periodic traffic with jitter, noise
// and flushes, under varied configuration and idling; the checker predicts
// and compares every result.
// ----------------------------------------------------------------------------
module tb_clock_skew_anomaly_detector_unit;
  import csad_pkg::*;

  localparam logic CMD_FRAME = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;
  localparam logic [CFG_IDX_W-1:0] UNUSED_REG = CFG_IDX_W'(REG_MIN_RUN) + CFG_IDX_W'(1);
  localparam logic [63:0] TS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [QW-1:0]        cfg_data_i;

  int fail_count, pending, reports_seen;
  int send_idle_pct, recv_stall_pct;
  int sent_frames, sent_flushes;
  logic [63:0] cur_time, cur_period;

  csad_in_if  in_ch ();
  csad_out_if out_ch ();

  clock_skew_anomaly_detector_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  csad_result_checker checker_u (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .reports_seen_o (reports_seen)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // stall the result side at the current rate
  always @(posedge clk_i) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    #200_000_000;
    $display("tb_clock_skew_anomaly_detector_unit: FAIL");
    $finish;
  end

  // hold one register write for a cycle; call cfg_close after a batch
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  task automatic cfg_close();
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // offer one request, with random idle cycles ahead of it
  task automatic send_request(logic cmd, logic [62:0] ts);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.command      <= cmd;
    in_ch.arrival_time <= ts;
    do @(negedge clk_i); while (!in_ch.ready);
    @(posedge clk_i);
    if (cmd == CMD_FLUSH) sent_flushes++;
    else sent_frames++;
  endtask

  // let every expected result come back, then settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic next_frame();
    logic [63:0] jitter;
    jitter   = {$urandom, $urandom} % ((cur_period >> 6) + 1);
    cur_time = ($urandom_range(1)) ? cur_time + cur_period + jitter
                                   : cur_time + cur_period - (jitter >> 1);
    if (cur_time > 64'h3FFF_FFFF_FFFF_FFFF) cur_time = 64'h100_0000_0000;
    send_request(CMD_FRAME, cur_time[62:0]);
  endtask

  task automatic run_phase(int n_items, int idle_pct, int stall_pct, logic [63:0] period,
                           logic [63:0] forget, bit pause_often);
    logic [63:0] dev;
    drain();
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    cur_period     = period;
    dev = {$urandom, $urandom} % (period >> 10);
    cfg_write(REG_NOMINAL_PERIOD, period);
    cfg_write(REG_BASE_MEAN, 64'($signed($urandom_range(2_000_000)) - 1_000_000));
    cfg_write(REG_BASE_DEV, dev);
    cfg_write(REG_ALARM_SIGMA, 64'($urandom_range(15, 1)));
    cfg_write(REG_FORGET_INV, forget);
    cfg_write(REG_INIT_COV, {1'b0, 31'($urandom), $urandom} | 64'd1);
    cfg_write(REG_MIN_RUN, 64'($urandom_range(6, 1)));
    cfg_close();
    for (int i = 0; i < n_items; i++) begin
      int pick;
      pick = $urandom_range(99);
      if (pick < 4) send_request(CMD_FLUSH, 63'({$urandom, $urandom}));
      else if (pick < 9) send_request(CMD_FRAME, 63'({$urandom, $urandom}));
      else next_frame();
      // hold off until all results are back
      if (pause_often && i % 25 == 24) drain();
    end
  endtask

  initial begin
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_idx_i          = '0;
    cfg_data_i         = '0;
    in_ch.valid        = 1'b0;
    in_ch.command      = CMD_FRAME;
    in_ch.arrival_time = '0;
    out_ch.ready       = 1'b0;
    send_idle_pct      = 0;
    recv_stall_pct     = 0;
    sent_frames        = 0;
    sent_flushes       = 0;
    cur_period         = 64'h1_0000_0000;
    cur_time           = 64'h100_0000_0000;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // starting covariance must land before the first frame
    cfg_write(REG_INIT_COV, {24'b0, 8'($urandom_range(255, 1)), 32'b0});
    cfg_write(UNUSED_REG, '1);
    cfg_close();

    // empty flush, origin, negative elapsed, timestamp extremes, double flush
    send_request(CMD_FLUSH, '0);
    send_request(CMD_FRAME, 63'h100_0000_0000);
    send_request(CMD_FRAME, 63'h101_0000_1234);
    send_request(CMD_FRAME, '0);
    send_request(CMD_FRAME, TS_MAX[62:0]);
    send_request(CMD_FLUSH, TS_MAX[62:0]);
    send_request(CMD_FLUSH, '0);

    // sigma zero and a zero minimum run
    drain();
    cfg_write(REG_ALARM_SIGMA, '0);
    cfg_write(REG_MIN_RUN, '0);
    cfg_close();
    repeat (3) next_frame();
    send_request(CMD_FLUSH, '0);

    // threshold too large to represent
    drain();
    cfg_write(REG_BASE_DEV, TS_MAX);
    cfg_write(REG_ALARM_SIGMA, 64'd15);
    cfg_close();
    repeat (2) next_frame();

    // offset overflow with the largest period, strong forgetting
    drain();
    cfg_write(REG_NOMINAL_PERIOD, TS_MAX);
    cfg_write(REG_FORGET_INV, 64'h2_0000_0000);
    cfg_write(REG_BASE_DEV, '0);
    cfg_write(REG_ALARM_SIGMA, 64'd1);
    cfg_write(REG_BASE_MEAN, 64'h8000_0000_0000_0000);
    cfg_close();
    repeat (3) next_frame();
    send_request(CMD_FLUSH, '0);

    // smallest period, no forgetting, longest minimum run
    drain();
    cfg_write(REG_NOMINAL_PERIOD, 64'd1);
    cfg_write(REG_FORGET_INV, 64'h1_0000_0000);
    cfg_write(REG_MIN_RUN, 64'd255);
    cfg_write(REG_BASE_MEAN, 64'h7FFF_FFFF_FFFF_FFFF);
    cfg_write(REG_INIT_COV, 64'd1);
    cfg_write(REG_INIT_COV, TS_MAX);
    cfg_close();
    repeat (2) next_frame();
    send_request(CMD_FLUSH, '0);

    // randomized phases
    run_phase(400, 0, 0, 64'h1_0000_0000, 64'h1_0295_FAD4, 1'b0);
    run_phase(400, 77, 0, 64'h1_0000_0000, 64'h1_0000_0000 + $urandom, 1'b0);
    run_phase(400, 0, 77, 64'h1000_0000, 64'h1_0000_0000 + $urandom, 1'b0);
    run_phase(400, 12, 12, 64'h1_0000_0000, 64'h1_0295_FAD4, 1'b1);
    run_phase(400, 0, 0, 64'h4000_0000, 64'h2_0000_0000, 1'b0);

    drain();
    $display("Covered %0d frames and %0d flushes; %0d run reports returned.",
             sent_frames, sent_flushes, reports_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_clock_skew_anomaly_detector_unit: PASS");
    end else begin
      $display("tb_clock_skew_anomaly_detector_unit: FAIL");
    end
    $finish;
  end

endmodule
